>>> sv/lip_pkg.sv
// ----------------------------------------------------------------------------
// lip_pkg
// Shared widths for the line intersection block.
// ----------------------------------------------------------------------------
package lip_pkg;

    localparam int OUT_BITS   = 48;
    localparam int CFG_BITS   = 32;
    localparam int COORD_BITS = 16;

endpackage

>>> sv/line_intersection_params_top.sv
// An input request passes stages 1 to 3, a chain of 2*COORD_BITS + 1 + FRACTION_BITS
// division cells and the output register before its result is valid.
// Throughput: one line pair per cycle; the division cells are fully pipelined and the
// whole pipe stalls only when out_valid is high and out_ready is low.
// The full quotient is compared against the output range; larger values saturate.
// Reset clears all valid bits and sets the parallel threshold register thr_reg to 1.
// ----------------------------------------------------------------------------
// line_intersection_params_top
// Cross products, a chain of division cells, then sign and saturation.
// ----------------------------------------------------------------------------
module line_intersection_params_top #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lip_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [15:0]            start_a_x,
    input  logic signed [15:0]            start_a_y,
    input  logic signed [15:0]            dir_a_x,
    input  logic signed [15:0]            dir_a_y,
    input  logic signed [15:0]            start_b_x,
    input  logic signed [15:0]            start_b_y,
    input  logic signed [15:0]            dir_b_x,
    input  logic signed [15:0]            dir_b_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic signed [lip_pkg::OUT_BITS-1:0] param_a,
    output logic signed [lip_pkg::OUT_BITS-1:0] param_b,
    output logic                          clipped
);
    import lip_pkg::*;

    // widths: product 2C, numerator needs 2C+2 signed, magnitude 2C+1
    localparam int PW = 2*COORD_BITS + 2;
    localparam int NW = 2*COORD_BITS + 1;
    localparam int QW = NW + FRACTION_BITS + 1;

    logic [CFG_BITS-1:0] thr_reg;
    logic                en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= CFG_BITS'(1);
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // stage 1: coordinates, differences
    logic                         v1_reg;
    logic signed [COORD_BITS:0]   wx_reg, wy_reg;
    logic signed [COORD_BITS-1:0] rax_reg, ray_reg, sbx_reg, sby_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg  <= (COORD_BITS+1)'(signed'(start_b_x[COORD_BITS-1:0]))
                     - (COORD_BITS+1)'(signed'(start_a_x[COORD_BITS-1:0]));
            wy_reg  <= (COORD_BITS+1)'(signed'(start_b_y[COORD_BITS-1:0]))
                     - (COORD_BITS+1)'(signed'(start_a_y[COORD_BITS-1:0]));
            rax_reg <= dir_a_x[COORD_BITS-1:0];
            ray_reg <= dir_a_y[COORD_BITS-1:0];
            sbx_reg <= dir_b_x[COORD_BITS-1:0];
            sby_reg <= dir_b_y[COORD_BITS-1:0];
        end
    end

    // stage 2: six products
    logic                 v2_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= PW'(rax_reg) * PW'(sby_reg);
            p1_reg <= PW'(ray_reg) * PW'(sbx_reg);
            p2_reg <= PW'(wx_reg) * PW'(sby_reg);
            p3_reg <= PW'(wy_reg) * PW'(sbx_reg);
            p4_reg <= PW'(wx_reg) * PW'(ray_reg);
            p5_reg <= PW'(wy_reg) * PW'(rax_reg);
        end
    end

    // stage 3: cross products, magnitudes, parallel check against the threshold
    logic signed [PW-1:0] den, nt, nu;
    logic [PW-1:0]        dm, ntm, num;
    logic                 par;

    always_comb
    begin
        den = p0_reg - p1_reg;
        nt  = p2_reg - p3_reg;
        nu  = p4_reg - p5_reg;
        dm  = den[PW-1] ? PW'(-den) : den;
        ntm = nt[PW-1] ? PW'(-nt) : nt;
        num = nu[PW-1] ? PW'(-nu) : nu;
        par = (dm == '0) || ({{(64-PW){1'b0}}, dm} < {32'd0, thr_reg});
    end

    logic          v3_reg;
    logic [NW-1:0] d3_reg, na3_reg, nb3_reg;
    logic [2:0]    f3_reg; // found, neg a, neg b

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d3_reg  <= dm[NW-1:0];
            na3_reg <= ntm[NW-1:0];
            nb3_reg <= num[NW-1:0];
            f3_reg  <= {!par, nt[PW-1] ^ den[PW-1], nu[PW-1] ^ den[PW-1]};
        end
    end

    // division chain: q starts with the numerator on top followed by zeros;
    // each cell moves one dividend bit into the remainder and one quotient bit
    // into the bottom, so NW + FRACTION_BITS steps give (n << FRACTION_BITS) / d.
    localparam int STEPS = NW + FRACTION_BITS;

    logic          cv   [0:STEPS];
    logic [NW-1:0] cd   [0:STEPS];
    logic [NW:0]   cra  [0:STEPS];
    logic [NW:0]   crb  [0:STEPS];
    logic [QW-1:0] cqa  [0:STEPS];
    logic [QW-1:0] cqb  [0:STEPS];
    logic [2:0]    cf   [0:STEPS];

    assign cv[0]  = v3_reg;
    assign cd[0]  = d3_reg;
    assign cra[0] = '0;
    assign crb[0] = '0;
    assign cqa[0] = {na3_reg, {(QW-NW){1'b0}}};
    assign cqb[0] = {nb3_reg, {(QW-NW){1'b0}}};
    assign cf[0]  = f3_reg;

    genvar g;
    generate
        for (g = 0; g < STEPS; g++)
        begin : g_cell
            lip_div_cell #(.NW(NW), .QW(QW)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en),
                .v_in(cv[g]), .d_in(cd[g]),
                .ra_in(cra[g]), .qa_in(cqa[g]),
                .rb_in(crb[g]), .qb_in(cqb[g]),
                .flags_in(cf[g]),
                .v_out(cv[g+1]), .d_out(cd[g+1]),
                .ra_out(cra[g+1]), .qa_out(cqa[g+1]),
                .rb_out(crb[g+1]), .qb_out(cqb[g+1]),
                .flags_out(cf[g+1])
            );
        end
    endgenerate

    // final: quotient bits are the low STEPS bits of q registers
    logic [STEPS-1:0]    qa_f, qb_f;
    logic [OUT_BITS-1:0] lim_a, lim_b, ra_o, rb_o;
    logic                ca, cb;

    always_comb
    begin
        qa_f  = cqa[STEPS][STEPS-1:0];
        qb_f  = cqb[STEPS][STEPS-1:0];
        lim_a = cf[STEPS][1] ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
        lim_b = cf[STEPS][0] ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
        ca = ({{(64-STEPS){1'b0}}, qa_f} > {{(64-OUT_BITS){1'b0}}, lim_a});
        cb = ({{(64-STEPS){1'b0}}, qb_f} > {{(64-OUT_BITS){1'b0}}, lim_b});
        ra_o = ca ? lim_a : OUT_BITS'(qa_f);
        rb_o = cb ? lim_b : OUT_BITS'(qb_f);
        if (cf[STEPS][1]) ra_o = OUT_BITS'(-ra_o);
        if (cf[STEPS][0]) rb_o = OUT_BITS'(-rb_o);
    end

    logic                ov_reg, fo_reg, cl_reg;
    logic [OUT_BITS-1:0] pa_reg, pb_reg;

    assign en = !ov_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= cv[STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fo_reg <= cf[STEPS][2];
            pa_reg <= cf[STEPS][2] ? ra_o : '0;
            pb_reg <= cf[STEPS][2] ? rb_o : '0;
            cl_reg <= cf[STEPS][2] && (ca || cb);
        end
    end

    assign in_ready  = en;
    assign out_valid = ov_reg;
    assign found     = fo_reg;
    assign param_a   = pa_reg;
    assign param_b   = pb_reg;
    assign clipped   = cl_reg;

endmodule

>>> sv/lip_div_cell.sv
// ----------------------------------------------------------------------------
// lip_div_cell
// One restoring-division step for two quotients that share a divisor.
// Registers its results and hands them to the next cell every cycle while en is high.
// ----------------------------------------------------------------------------
module lip_div_cell #(
    parameter int NW = 34,
    parameter int QW = 58
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          v_in,
    input  logic [NW-1:0] d_in,
    input  logic [NW:0]   ra_in,
    input  logic [QW-1:0] qa_in,
    input  logic [NW:0]   rb_in,
    input  logic [QW-1:0] qb_in,
    input  logic [2:0]    flags_in,
    output logic          v_out,
    output logic [NW-1:0] d_out,
    output logic [NW:0]   ra_out,
    output logic [QW-1:0] qa_out,
    output logic [NW:0]   rb_out,
    output logic [QW-1:0] qb_out,
    output logic [2:0]    flags_out
);

    logic          v_reg;
    logic [NW-1:0] d_reg;
    logic [NW:0]   ra_reg, rb_reg, ra_next, rb_next;
    logic [QW-1:0] qa_reg, qb_reg, qa_next, qb_next;
    logic [2:0]    flags_reg;
    logic [NW+1:0] sa, sb;

    // pull the next dividend bit from the top of q into the remainder
    always_comb
    begin
        sa = {ra_in, qa_in[QW-1]};
        sb = {rb_in, qb_in[QW-1]};
        qa_next = {qa_in[QW-2:0], 1'b0};
        qb_next = {qb_in[QW-2:0], 1'b0};
        ra_next = sa[NW:0];
        rb_next = sb[NW:0];
        if (sa >= {2'b00, d_in})
        begin
            ra_next    = (NW+1)'(sa - {2'b00, d_in});
            qa_next[0] = 1'b1;
        end
        if (sb >= {2'b00, d_in})
        begin
            rb_next    = (NW+1)'(sb - {2'b00, d_in});
            qb_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= d_in;
            ra_reg    <= ra_next;
            rb_reg    <= rb_next;
            qa_reg    <= qa_next;
            qb_reg    <= qb_next;
            flags_reg <= flags_in;
        end
    end

    assign v_out     = v_reg;
    assign d_out     = d_reg;
    assign ra_out    = ra_reg;
    assign rb_out    = rb_reg;
    assign qa_out    = qa_reg;
    assign qb_out    = qb_reg;
    assign flags_out = flags_reg;

endmodule
